>>> rtl/mlmh_pkg.sv
`timescale 1ns / 1ps
// Package for the multilevel multihash set unit.
// Holds geometry constants, status codes, payload structs and the hash helpers.
package mlmh_pkg;

  localparam int unsigned BaseSize   = 256;
  localparam int unsigned Levels     = 4;
  localparam int unsigned NumHashes  = 4;
  localparam int unsigned BaseBits   = $clog2(BaseSize);
  localparam int unsigned LevelBits  = (Levels > 1) ? $clog2(Levels) : 1;
  localparam int unsigned StoreDepth = BaseSize * ((1 << Levels) - 1);
  localparam int unsigned AddrBits   = $clog2(StoreDepth);
  localparam int unsigned EntryBits  = 65;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgBits    = 32;

  localparam logic [2:0] StInserted = 3'd0;
  localparam logic [2:0] StPresent  = 3'd1;
  localparam logic [2:0] StFound    = 3'd2;
  localparam logic [2:0] StAbsent   = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  localparam logic OpInsert = 1'b0;
  localparam logic OpQuery  = 1'b1;

  localparam logic [CfgIdxBits-1:0] RegSeed0 = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegSeed1 = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegSeed2 = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegSeed3 = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegHashes = 3'd4;

  typedef struct packed {
    logic        opcode;
    logic [63:0] key;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  level;
    logic [10:0] slot;
  } out_word_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

  // First half of a block mix: scramble the key word (one multiply and a rotate).
  function automatic logic [31:0] mix_k1(input logic [31:0] k);
    mix_k1 = rotl(k * 32'hcc9e2d51, 15);
  endfunction

  function automatic logic [31:0] mix_h(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] t;
    t = rotl(h ^ k, 13);
    mix_h = t * 32'd5 + 32'he6546b64;
  endfunction

  function automatic logic [31:0] fmix_a(input logic [31:0] h);
    fmix_a = h ^ (h >> 16);
  endfunction

endpackage

>>> rtl/mlmh_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
// No dependencies.
module mlmh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> rtl/mlmh_hash.sv
`timescale 1ns / 1ps
// Multi-cycle 32-bit mix-and-multiply hash of a 64-bit key, one multiply per cycle.
// Depends on mlmh_pkg.
module mlmh_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] key_i,
  input  logic [31:0] seed_i,
  output logic        done_o,
  output logic [31:0] hash_o
);
  localparam logic [3:0] HIdle = 4'd0;
  localparam logic [3:0] HK0a  = 4'd1;
  localparam logic [3:0] HK0b  = 4'd2;
  localparam logic [3:0] HH0   = 4'd3;
  localparam logic [3:0] HK1a  = 4'd4;
  localparam logic [3:0] HK1b  = 4'd5;
  localparam logic [3:0] HH1   = 4'd6;
  localparam logic [3:0] HF1   = 4'd7;
  localparam logic [3:0] HF2   = 4'd8;
  localparam logic [3:0] HDone = 4'd9;

  logic [3:0]  state_q, state_d;
  logic [31:0] h_q, h_d, k_q, k_d;
  logic [63:0] key_q, key_d;

  always_comb begin
    state_d = state_q;
    h_d = h_q;
    k_d = k_q;
    key_d = key_q;
    case (state_q)
      HIdle: begin
        if (start_i) begin
          h_d = seed_i;
          key_d = key_i;
          state_d = HK0a;
        end
      end
      HK0a: begin
        k_d = mlmh_pkg::mix_k1(key_q[31:0]);
        state_d = HK0b;
      end
      HK0b: begin
        k_d = k_q * 32'h1b873593;
        state_d = HH0;
      end
      HH0: begin
        h_d = mlmh_pkg::mix_h(h_q, k_q);
        state_d = HK1a;
      end
      HK1a: begin
        k_d = mlmh_pkg::mix_k1(key_q[63:32]);
        state_d = HK1b;
      end
      HK1b: begin
        k_d = k_q * 32'h1b873593;
        state_d = HH1;
      end
      HH1: begin
        h_d = mlmh_pkg::fmix_a(mlmh_pkg::mix_h(h_q, k_q) ^ 32'd8);
        state_d = HF1;
      end
      HF1: begin
        h_d = h_q * 32'h85ebca6b;
        h_d = h_d ^ (h_d >> 13);
        state_d = HF2;
      end
      HF2: begin
        h_d = h_q * 32'hc2b2ae35;
        h_d = mlmh_pkg::fmix_a(h_d);
        state_d = HDone;
      end
      HDone: state_d = HIdle;
      default: state_d = HIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    k_q <= k_d;
    key_q <= key_d;
  end

  assign done_o = (state_q == HDone);
  assign hash_o = h_q;
endmodule

>>> rtl/multilevel_multihash_set_unit.sv
`timescale 1ns / 1ps
// Multilevel multihash set of 64-bit keys: top level.
// Depends on mlmh_pkg, mlmh_hash and mlmh_ram.
//
// Use: pulse start with a word on in_i while busy is low. The unit probes
// the open levels in order and, within each level, the configured seeds in
// order. Each probe hashes the key in the hash unit, reads the entry store
// and checks the entry; a growing insert adds one more hash and a write.
// The result appears on out_o for exactly one cycle with out_valid_o high;
// the receiver cannot stall. busy is high from the accepting edge until
// the result cycle ends.
// Configuration: write cfg_we_i/cfg_idx_i/cfg_data_i while idle; indexes 0
// to 3 are the seeds, 4 the number of seeds probed per level.
// Reset: after rst_ni the unit clears the entry store's valid bits, one entry
// a cycle, for all StoreDepth (3840) entries with busy high; configuration
// writes are taken during that pass. One level is open after reset.
module multilevel_multihash_set_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  mlmh_pkg::in_word_t                  in_i,
  output logic                                out_valid_o,
  output mlmh_pkg::out_word_t                 out_o,
  input  logic                                cfg_we_i,
  input  logic [mlmh_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [mlmh_pkg::CfgBits-1:0]        cfg_data_i
);
  localparam int unsigned AB = mlmh_pkg::AddrBits;
  localparam int unsigned LB = mlmh_pkg::LevelBits;

  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SHash  = 3'd2;
  localparam logic [2:0] SRead  = 3'd3;
  localparam logic [2:0] SCheck = 3'd4;
  localparam logic [2:0] SGrow  = 3'd5;
  localparam logic [2:0] SOut   = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [31:0] seed_q [4];
  logic [2:0]  nh_q;
  logic [LB:0] open_q, open_d;
  logic [AB-1:0] clr_q, clr_d;
  logic        op_q, op_d;
  logic [63:0] key_q, key_d;
  logic [LB-1:0] lvl_q, lvl_d;
  logic [1:0]  hix_q, hix_d;
  logic [2:0]  nh_eff;
  logic [AB-1:0] addr_q, addr_d;
  logic [10:0] slot_q, slot_d;
  logic        grow_q, grow_d;
  mlmh_pkg::out_word_t res_q, res_d;

  logic        h_start, h_done;
  logic [31:0] h_out;
  logic [31:0] h_seed;
  logic        ram_we;
  logic [AB-1:0] ram_addr;
  logic [mlmh_pkg::EntryBits-1:0] ram_wdata, ram_rdata;
  logic [AB:0] lvl_base;
  logic [AB:0] lvl_mask;

  always_comb begin
    if (nh_q == 3'd0) nh_eff = 3'd1;
    else if (nh_q > 3'(mlmh_pkg::NumHashes)) nh_eff = 3'(mlmh_pkg::NumHashes);
    else nh_eff = nh_q;
  end

  assign lvl_base = (AB+1)'(mlmh_pkg::BaseSize) * (((AB+1)'(1) << lvl_q) - (AB+1)'(1));
  assign lvl_mask = ((AB+1)'(mlmh_pkg::BaseSize) << lvl_q) - (AB+1)'(1);
  assign h_seed = grow_q ? seed_q[0] : seed_q[hix_q];

  mlmh_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(h_start),
    .key_i  (key_q),
    .seed_i (h_seed),
    .done_o (h_done),
    .hash_o (h_out)
  );

  mlmh_ram #(.Width(mlmh_pkg::EntryBits), .Depth(mlmh_pkg::StoreDepth)) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    open_d = open_q;
    clr_d = clr_q;
    op_d = op_q;
    key_d = key_q;
    lvl_d = lvl_q;
    hix_d = hix_q;
    addr_d = addr_q;
    slot_d = slot_q;
    grow_d = grow_q;
    res_d = res_q;
    h_start = 1'b0;
    ram_we = 1'b0;
    ram_addr = addr_q;
    ram_wdata = {1'b1, key_q};
    case (state_q)
      SClear: begin
        ram_we = 1'b1;
        ram_addr = clr_q;
        ram_wdata = '0;
        clr_d = clr_q + AB'(1);
        if (clr_q == AB'(mlmh_pkg::StoreDepth - 1)) state_d = SIdle;
      end
      SIdle: begin
        if (start) begin
          op_d = in_i.opcode;
          key_d = in_i.key;
          lvl_d = '0;
          hix_d = '0;
          grow_d = 1'b0;
          state_d = SHash;
        end
      end
      SHash: begin
        // hash unit idles in this state until kicked once
        h_start = 1'b1;
        state_d = SRead;
      end
      SRead: begin
        if (h_done) begin
          slot_d = 11'(h_out & 32'(lvl_mask));
          addr_d = AB'(lvl_base + (AB+1)'(h_out & 32'(lvl_mask)));
          state_d = grow_q ? SGrow : SCheck;
        end
      end
      SCheck: begin
        // first pass presents addr_q; second pass checks the read entry
        if (!grow_q) begin
          grow_d = 1'b1; // reuse as read-pending marker
          state_d = SCheck;
        end
        if (grow_q) begin
          grow_d = 1'b0;
          state_d = SOut;
          if (!ram_rdata[64]) begin
            if (op_q == mlmh_pkg::OpInsert) begin
              ram_we = 1'b1;
              res_d = '{mlmh_pkg::StInserted, 2'(lvl_q), 11'(slot_q)};
            end else begin
              res_d = '{mlmh_pkg::StAbsent, 2'd0, 11'd0};
            end
          end else if (ram_rdata[63:0] == key_q) begin
            res_d = '{(op_q == mlmh_pkg::OpInsert) ? mlmh_pkg::StPresent
                      : mlmh_pkg::StFound, 2'(lvl_q), 11'(slot_q)};
          end else if ({1'b0, hix_q} + 3'd1 < nh_eff) begin
            hix_d = hix_q + 2'd1;
            state_d = SHash;
          end else if ({1'b0, lvl_q} + (LB+1)'(1) < open_q) begin
            hix_d = '0;
            lvl_d = lvl_q + LB'(1);
            state_d = SHash;
          end else if (op_q == mlmh_pkg::OpQuery) begin
            res_d = '{mlmh_pkg::StAbsent, 2'd0, 11'd0};
          end else if (open_q >= (LB+1)'(mlmh_pkg::Levels)) begin
            res_d = '{mlmh_pkg::StFull, 2'd0, 11'd0};
          end else begin
            lvl_d = LB'(open_q);
            open_d = open_q + (LB+1)'(1);
            grow_d = 1'b1;
            state_d = SHash;
          end
        end
      end
      SGrow: begin
        ram_we = 1'b1;
        grow_d = 1'b0;
        res_d = '{mlmh_pkg::StInserted, 2'(lvl_q), 11'(slot_q)};
        state_d = SOut;
      end
      SOut: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      clr_q <= '0;
      open_q <= (LB+1)'(1);
      grow_q <= 1'b0;
      seed_q[0] <= '0;
      seed_q[1] <= '0;
      seed_q[2] <= '0;
      seed_q[3] <= '0;
      nh_q <= 3'd1;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      open_q <= open_d;
      grow_q <= grow_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mlmh_pkg::RegSeed0: seed_q[0] <= cfg_data_i;
          mlmh_pkg::RegSeed1: seed_q[1] <= cfg_data_i;
          mlmh_pkg::RegSeed2: seed_q[2] <= cfg_data_i;
          mlmh_pkg::RegSeed3: seed_q[3] <= cfg_data_i;
          mlmh_pkg::RegHashes: nh_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    key_q <= key_d;
    lvl_q <= lvl_d;
    hix_q <= hix_d;
    addr_q <= addr_d;
    slot_q <= slot_d;
    res_q <= res_d;
  end

  assign busy = (state_q != SIdle);
  assign out_valid_o = (state_q == SOut);
  assign out_o = res_q;
endmodule
